@@ rtl/i2cbm_pkg.sv @@
// shared types and constants of the i2c bit-level master
`default_nettype none
package i2cbm_pkg;

    localparam int DATA_BITS   = 8;
    localparam int BIT_CNT_W   = $clog2(DATA_BITS + 1);
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 8;

    typedef enum logic [2:0] {
        MODE_TICK  = 3'd0,
        MODE_START = 3'd1,
        MODE_STOP  = 3'd2,
        MODE_WRITE = 3'd3,
        MODE_READ  = 3'd4,
        MODE_WAIT  = 3'd5,
        MODE_ACK   = 3'd6,
        MODE_NACK  = 3'd7
    } mode_t;

    localparam logic [CFG_INDEX_W-1:0] CFG_SETUP   = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] CFG_HALF    = CFG_INDEX_W'(1);
    localparam logic [CFG_INDEX_W-1:0] CFG_SETTLE  = CFG_INDEX_W'(2);
    localparam logic [CFG_INDEX_W-1:0] CFG_TIMEOUT = CFG_INDEX_W'(3);

    localparam logic [7:0] SETUP_RESET   = 8'd4;
    localparam logic [7:0] HALF_RESET    = 8'd2;
    localparam logic [7:0] SETTLE_RESET  = 8'd1;
    localparam logic [7:0] TIMEOUT_RESET = 8'd250;

    typedef enum logic [17:0] {
        PH_IDLE    = 18'd1 << 0,
        PH_ST_A    = 18'd1 << 1,
        PH_ST_B    = 18'd1 << 2,
        PH_SP_A    = 18'd1 << 3,
        PH_WA_A    = 18'd1 << 4,
        PH_WA_B    = 18'd1 << 5,
        PH_WA_POLL = 18'd1 << 6,
        PH_WA_END  = 18'd1 << 7,
        PH_AK_A    = 18'd1 << 8,
        PH_AK_B    = 18'd1 << 9,
        PH_AK_C    = 18'd1 << 10,
        PH_NK_A    = 18'd1 << 11,
        PH_NK_B    = 18'd1 << 12,
        PH_WR_LOW  = 18'd1 << 13,
        PH_WR_HIGH = 18'd1 << 14,
        PH_WR_GAP  = 18'd1 << 15,
        PH_RD_LOW  = 18'd1 << 16,
        PH_RD_HIGH = 18'd1 << 17
    } phase_t;

    typedef struct packed {
        logic [7:0] setup_ticks;
        logic [7:0] half_bit_ticks;
        logic [7:0] ack_settle_ticks;
        logic [7:0] ack_timeout;
    } cfg_t;

    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_data;
        logic       ack_error;
    } result_t;

    // a hold of zero ticks counts as one
    function automatic logic [7:0] hold_len(input logic [7:0] ticks);
        hold_len = (ticks == 8'd0) ? 8'd1 : ticks;
    endfunction

endpackage
`default_nettype wire

@@ rtl/i2cbm_if.sv @@
// channel interfaces: item input, result output, configuration write
`default_nettype none
interface i2cbm_item_if;
    logic       valid;
    logic       ready;
    logic [2:0] mode;
    logic [7:0] write_data;
    logic       sda_in;

    modport source (output valid, output mode, output write_data, output sda_in,
                    input ready);
    modport sink (input valid, input mode, input write_data, input sda_in,
                  output ready);
endinterface

interface i2cbm_result_if;
    logic       valid;
    logic       ready;
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
    logic       ack_error;

    modport source (output valid, output scl_out, output sda_out, output busy_res,
                    output done_res, output read_data, output ack_error, input ready);
    modport sink (input valid, input scl_out, input sda_out, input busy_res,
                  input done_res, input read_data, input ack_error, output ready);
endinterface

interface i2cbm_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] index;
    logic [7:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

@@ rtl/i2cbm_seq.sv @@
// bus sequencer state and per-item next-state logic
`default_nettype none
module i2cbm_seq
    import i2cbm_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       take,
    input  wire logic [2:0] mode,
    input  wire logic [7:0] write_data,
    input  wire logic       sda_in,
    input  wire cfg_t       cfg,
    output result_t         result
);

    phase_t                 phase_reg, phase_next;
    logic [7:0]             hold_count_reg, hold_count_next;
    logic [BIT_CNT_W-1:0]   bit_count_reg, bit_count_next;
    logic [DATA_BITS-1:0]   shift_reg, shift_next;
    logic [7:0]             poll_count_reg, poll_count_next;
    logic                   scl_level_reg, scl_level_next;
    logic                   sda_level_reg, sda_level_next;
    logic                   error_flag_reg, error_flag_next;
    logic [7:0]             read_word_reg, read_word_next;
    logic                   done;

    always_comb
    begin
        logic [7:0]           hc;
        logic [DATA_BITS-1:0] shifted;
        phase_next      = phase_reg;
        hold_count_next = hold_count_reg;
        bit_count_next  = bit_count_reg;
        shift_next      = shift_reg;
        poll_count_next = poll_count_reg;
        scl_level_next  = scl_level_reg;
        sda_level_next  = sda_level_reg;
        error_flag_next = error_flag_reg;
        read_word_next  = read_word_reg;
        done            = 1'b0;
        hc              = hold_count_reg;
        shifted         = '0;

        if (mode_t'(mode) != MODE_TICK) begin
            if (phase_reg == PH_IDLE) begin
                bit_count_next = '0;
                case (mode_t'(mode))
                    MODE_START:
                    begin
                        sda_level_next  = 1'b1;
                        scl_level_next  = 1'b1;
                        hold_count_next = hold_len(cfg.setup_ticks);
                        phase_next      = PH_ST_A;
                    end
                    MODE_STOP:
                    begin
                        sda_level_next  = 1'b0;
                        scl_level_next  = 1'b1;
                        hold_count_next = hold_len(cfg.setup_ticks);
                        phase_next      = PH_SP_A;
                    end
                    MODE_WRITE:
                    begin
                        shift_next      = DATA_BITS'(write_data);
                        scl_level_next  = 1'b0;
                        sda_level_next  = shift_next[DATA_BITS-1];
                        hold_count_next = hold_len(cfg.half_bit_ticks);
                        phase_next      = PH_WR_LOW;
                    end
                    MODE_READ:
                    begin
                        shift_next      = '0;
                        scl_level_next  = 1'b0;
                        hold_count_next = hold_len(cfg.half_bit_ticks);
                        phase_next      = PH_RD_LOW;
                    end
                    MODE_WAIT:
                    begin
                        error_flag_next = 1'b0;
                        sda_level_next  = 1'b1;
                        hold_count_next = hold_len(cfg.ack_settle_ticks);
                        phase_next      = PH_WA_A;
                    end
                    MODE_ACK:
                    begin
                        scl_level_next  = 1'b0;
                        sda_level_next  = 1'b0;
                        hold_count_next = hold_len(cfg.half_bit_ticks);
                        phase_next      = PH_AK_A;
                    end
                    default:
                    begin
                        scl_level_next  = 1'b0;
                        sda_level_next  = 1'b1;
                        hold_count_next = hold_len(cfg.half_bit_ticks);
                        phase_next      = PH_NK_A;
                    end
                endcase
            end
        end else if (phase_reg == PH_WA_POLL) begin
            if (!sda_in) begin
                scl_level_next  = 1'b0;
                hold_count_next = hold_len(cfg.ack_settle_ticks);
                phase_next      = PH_WA_END;
            end else if (poll_count_reg >= cfg.ack_timeout) begin
                // timeout: flag it and fall into the stop sequence
                error_flag_next = 1'b1;
                sda_level_next  = 1'b0;
                scl_level_next  = 1'b1;
                hold_count_next = hold_len(cfg.setup_ticks);
                phase_next      = PH_SP_A;
            end else begin
                poll_count_next = poll_count_reg + 8'd1;
            end
        end else if (phase_reg != PH_IDLE) begin
            if (hc != 8'd0) begin
                hc = hc - 8'd1;
            end
            hold_count_next = hc;
            if (hc == 8'd0) begin
                case (phase_reg)
                    PH_ST_A:
                    begin
                        sda_level_next  = 1'b0;
                        hold_count_next = hold_len(cfg.setup_ticks);
                        phase_next      = PH_ST_B;
                    end
                    PH_ST_B:
                    begin
                        scl_level_next = 1'b0;
                        done           = 1'b1;
                    end
                    PH_SP_A:
                    begin
                        sda_level_next = 1'b1;
                        done           = 1'b1;
                    end
                    PH_WA_A:
                    begin
                        scl_level_next  = 1'b1;
                        hold_count_next = hold_len(cfg.ack_settle_ticks);
                        phase_next      = PH_WA_B;
                    end
                    PH_WA_B:
                    begin
                        phase_next      = PH_WA_POLL;
                        poll_count_next = 8'd0;
                    end
                    PH_AK_A, PH_NK_A:
                    begin
                        scl_level_next  = 1'b1;
                        hold_count_next = hold_len(cfg.half_bit_ticks);
                        phase_next      = (phase_reg == PH_AK_A) ? PH_AK_B : PH_NK_B;
                    end
                    PH_AK_B:
                    begin
                        scl_level_next  = 1'b0;
                        hold_count_next = hold_len(cfg.half_bit_ticks);
                        phase_next      = PH_AK_C;
                    end
                    PH_AK_C:
                    begin
                        sda_level_next = 1'b1;
                        done           = 1'b1;
                    end
                    PH_NK_B:
                    begin
                        scl_level_next = 1'b0;
                        done           = 1'b1;
                    end
                    PH_WR_LOW:
                    begin
                        scl_level_next  = 1'b1;
                        hold_count_next = hold_len(cfg.half_bit_ticks);
                        phase_next      = PH_WR_HIGH;
                    end
                    PH_WR_HIGH:
                    begin
                        scl_level_next  = 1'b0;
                        shift_next      = {shift_reg[DATA_BITS-2:0], 1'b0};
                        bit_count_next  = bit_count_reg + BIT_CNT_W'(1);
                        hold_count_next = hold_len(cfg.half_bit_ticks);
                        phase_next      = PH_WR_GAP;
                    end
                    PH_WR_GAP:
                    begin
                        if (bit_count_reg >= BIT_CNT_W'(DATA_BITS)) begin
                            done = 1'b1;
                        end else begin
                            sda_level_next  = shift_reg[DATA_BITS-1];
                            hold_count_next = hold_len(cfg.half_bit_ticks);
                            phase_next      = PH_WR_LOW;
                        end
                    end
                    PH_RD_LOW:
                    begin
                        scl_level_next  = 1'b1;
                        hold_count_next = hold_len(cfg.ack_settle_ticks);
                        phase_next      = PH_RD_HIGH;
                    end
                    PH_RD_HIGH:
                    begin
                        shifted        = {shift_reg[DATA_BITS-2:0], sda_in};
                        shift_next     = shifted;
                        bit_count_next = bit_count_reg + BIT_CNT_W'(1);
                        if (bit_count_next >= BIT_CNT_W'(DATA_BITS)) begin
                            read_word_next = shifted[7:0];
                            done           = 1'b1;
                        end else begin
                            scl_level_next  = 1'b0;
                            hold_count_next = hold_len(cfg.half_bit_ticks);
                            phase_next      = PH_RD_LOW;
                        end
                    end
                    default:
                    begin
                        done = 1'b1;
                    end
                endcase
                if (done) begin
                    phase_next = PH_IDLE;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg      <= PH_IDLE;
            hold_count_reg <= '0;
            bit_count_reg  <= '0;
            shift_reg      <= '0;
            poll_count_reg <= '0;
            scl_level_reg  <= 1'b1;
            sda_level_reg  <= 1'b1;
            error_flag_reg <= 1'b0;
            read_word_reg  <= '0;
        end else if (take) begin
            phase_reg      <= phase_next;
            hold_count_reg <= hold_count_next;
            bit_count_reg  <= bit_count_next;
            shift_reg      <= shift_next;
            poll_count_reg <= poll_count_next;
            scl_level_reg  <= scl_level_next;
            sda_level_reg  <= sda_level_next;
            error_flag_reg <= error_flag_next;
            read_word_reg  <= read_word_next;
        end
    end

    always_comb
    begin
        result.scl_out   = scl_level_next;
        result.sda_out   = sda_level_next;
        result.busy_res  = (phase_next != PH_IDLE);
        result.done_res  = done;
        result.read_data = read_word_next;
        result.ack_error = error_flag_next;
    end

endmodule
`default_nettype wire

@@ rtl/i2c_bit_level_master_core.sv @@
// i2c bit-level master: top level with configuration registers and result register
//
// items carries one entry per microsecond tick or command: mode 0 is a tick with
// the sampled sda level in sda_in, modes 1..7 are start, stop, write byte, read
// byte, wait for ack, ack and nack. commands given while busy are ignored.
// every accepted item gives exactly one transfer on results with the pin levels
// (scl_out, sda_out), busy_res, a done_res pulse, read_data and ack_error.
// the result of an item is registered and sits in the result register on the
// cycle after its transfer. one item per cycle is taken while results drains;
// when the receiver stalls, the result register holds and items.ready drops
// until that result is taken, so nothing is lost or reordered.
// cfg writes registers 0 setup_ticks, 1 half_bit_ticks, 2 ack_settle_ticks and
// 3 ack_timeout; other indexes are dropped. cfg.ready is always high.
// reset puts the bus sequencer idle with scl and sda released, clears the error
// and read byte, and loads the register defaults 4, 2, 1 and 250.
`default_nettype none
module i2c_bit_level_master_core
    import i2cbm_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    i2cbm_item_if.sink     items,
    i2cbm_result_if.source results,
    i2cbm_cfg_if.sink      cfg
);

    cfg_t    cfg_reg;
    result_t seq_result;
    result_t res_reg;
    logic    res_valid_reg;
    logic    take;

    assign cfg.ready   = 1'b1;
    assign items.ready = !res_valid_reg || results.ready;
    assign take        = items.valid && items.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg.setup_ticks      <= SETUP_RESET;
            cfg_reg.half_bit_ticks   <= HALF_RESET;
            cfg_reg.ack_settle_ticks <= SETTLE_RESET;
            cfg_reg.ack_timeout      <= TIMEOUT_RESET;
        end else if (cfg.valid) begin
            case (cfg.index)
                CFG_SETUP:   cfg_reg.setup_ticks      <= cfg.data;
                CFG_HALF:    cfg_reg.half_bit_ticks   <= cfg.data;
                CFG_SETTLE:  cfg_reg.ack_settle_ticks <= cfg.data;
                CFG_TIMEOUT: cfg_reg.ack_timeout      <= cfg.data;
                default:     ;
            endcase
        end
    end

    i2cbm_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .take       (take),
        .mode       (items.mode),
        .write_data (items.write_data),
        .sda_in     (items.sda_in),
        .cfg        (cfg_reg),
        .result     (seq_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            res_valid_reg <= 1'b0;
        end else if (take) begin
            res_valid_reg <= 1'b1;
        end else if (results.ready) begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take) begin
            res_reg <= seq_result;
        end
    end

    assign results.valid     = res_valid_reg;
    assign results.scl_out   = res_reg.scl_out;
    assign results.sda_out   = res_reg.sda_out;
    assign results.busy_res  = res_reg.busy_res;
    assign results.done_res  = res_reg.done_res;
    assign results.read_data = res_reg.read_data;
    assign results.ack_error = res_reg.ack_error;

endmodule
`default_nettype wire

@@ sim/i2cbm_sequence_check.sv @@
// i2c bit-level master: pin-level predictor and result comparison on the item channels
module i2cbm_sequence_check
    import i2cbm_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    i2cbm_item_if     items,
    i2cbm_result_if   results,
    i2cbm_cfg_if      cfg,
    output int        mismatches,
    output int        pending,
    output logic      seq_busy,
    output int        results_seen,
    output int        dones_seen,
    output int        timeouts_seen
);

    cfg_t                 timing;
    phase_t               ph;
    logic [7:0]           hold_left;
    int unsigned          bits_moved;
    logic [DATA_BITS-1:0] shifter;
    logic [DATA_BITS-1:0] last_read;
    logic [7:0]           polls;
    logic                 scl_lvl;
    logic                 sda_lvl;
    logic                 nak_err;
    result_t              pins_q[$];
    result_t              want;

    // a hold of zero still lasts one tick
    function void arm(input logic [7:0] ticks, input phase_t nxt);
        hold_left = (ticks == 8'd0) ? 8'd1 : ticks;
        ph = nxt;
    endfunction

    function void stop_edge();
        sda_lvl = 1'b0;
        scl_lvl = 1'b1;
        arm(timing.setup_ticks, PH_SP_A);
    endfunction

    // runs when the current hold has expired; returns 1 when the command completes
    function bit hold_expired(input logic s);
        hold_expired = 1'b0;
        case (ph)
            PH_ST_A:
            begin
                sda_lvl = 1'b0;
                arm(timing.setup_ticks, PH_ST_B);
            end
            PH_ST_B:
            begin
                scl_lvl = 1'b0;
                hold_expired = 1'b1;
            end
            PH_SP_A:
            begin
                sda_lvl = 1'b1;
                hold_expired = 1'b1;
            end
            PH_WA_A:
            begin
                scl_lvl = 1'b1;
                arm(timing.ack_settle_ticks, PH_WA_B);
            end
            PH_WA_B:
            begin
                ph = PH_WA_POLL;
                polls = 8'd0;
            end
            PH_AK_A:
            begin
                scl_lvl = 1'b1;
                arm(timing.half_bit_ticks, PH_AK_B);
            end
            PH_AK_B:
            begin
                scl_lvl = 1'b0;
                arm(timing.half_bit_ticks, PH_AK_C);
            end
            PH_AK_C:
            begin
                sda_lvl = 1'b1;
                hold_expired = 1'b1;
            end
            PH_NK_A:
            begin
                scl_lvl = 1'b1;
                arm(timing.half_bit_ticks, PH_NK_B);
            end
            PH_NK_B:
            begin
                scl_lvl = 1'b0;
                hold_expired = 1'b1;
            end
            PH_WR_LOW:
            begin
                scl_lvl = 1'b1;
                arm(timing.half_bit_ticks, PH_WR_HIGH);
            end
            PH_WR_HIGH:
            begin
                scl_lvl = 1'b0;
                shifter = shifter << 1;
                bits_moved++;
                arm(timing.half_bit_ticks, PH_WR_GAP);
            end
            PH_WR_GAP:
            begin
                if (bits_moved >= DATA_BITS)
                    hold_expired = 1'b1;
                else
                begin
                    sda_lvl = shifter[DATA_BITS-1];
                    arm(timing.half_bit_ticks, PH_WR_LOW);
                end
            end
            PH_RD_LOW:
            begin
                scl_lvl = 1'b1;
                arm(timing.ack_settle_ticks, PH_RD_HIGH);
            end
            PH_RD_HIGH:
            begin
                // sample taken on the last tick of the scl-high hold
                shifter = {shifter[DATA_BITS-2:0], s};
                bits_moved++;
                if (bits_moved >= DATA_BITS)
                begin
                    last_read = shifter;
                    hold_expired = 1'b1;
                end
                else
                begin
                    scl_lvl = 1'b0;
                    arm(timing.half_bit_ticks, PH_RD_LOW);
                end
            end
            default:
                hold_expired = 1'b1;
        endcase
    endfunction

    function result_t next_pins(input mode_t m, input logic [7:0] wd, input logic s);
        logic finished;
        finished = 1'b0;
        if (m != MODE_TICK)
        begin
            // commands only land while idle
            if (ph == PH_IDLE)
            begin
                bits_moved = 0;
                case (m)
                    MODE_START:
                    begin
                        sda_lvl = 1'b1;
                        scl_lvl = 1'b1;
                        arm(timing.setup_ticks, PH_ST_A);
                    end
                    MODE_STOP:
                        stop_edge();
                    MODE_WRITE:
                    begin
                        shifter = DATA_BITS'(wd);
                        scl_lvl = 1'b0;
                        sda_lvl = shifter[DATA_BITS-1];
                        arm(timing.half_bit_ticks, PH_WR_LOW);
                    end
                    MODE_READ:
                    begin
                        shifter = '0;
                        scl_lvl = 1'b0;
                        arm(timing.half_bit_ticks, PH_RD_LOW);
                    end
                    MODE_WAIT:
                    begin
                        nak_err = 1'b0;
                        sda_lvl = 1'b1;
                        arm(timing.ack_settle_ticks, PH_WA_A);
                    end
                    MODE_ACK:
                    begin
                        scl_lvl = 1'b0;
                        sda_lvl = 1'b0;
                        arm(timing.half_bit_ticks, PH_AK_A);
                    end
                    default:
                    begin
                        scl_lvl = 1'b0;
                        sda_lvl = 1'b1;
                        arm(timing.half_bit_ticks, PH_NK_A);
                    end
                endcase
            end
        end
        else if (ph == PH_WA_POLL)
        begin
            if (!s)
            begin
                scl_lvl = 1'b0;
                arm(timing.ack_settle_ticks, PH_WA_END);
            end
            else if (polls >= timing.ack_timeout)
            begin
                nak_err = 1'b1;
                timeouts_seen++;
                stop_edge();
            end
            else
                polls++;
        end
        else if (ph != PH_IDLE)
        begin
            if (hold_left > 8'd0)
                hold_left--;
            if (hold_left == 8'd0)
            begin
                finished = hold_expired(s);
                if (finished)
                    ph = PH_IDLE;
            end
        end
        next_pins.scl_out   = scl_lvl;
        next_pins.sda_out   = sda_lvl;
        next_pins.busy_res  = (ph != PH_IDLE);
        next_pins.done_res  = finished;
        next_pins.read_data = last_read[7:0];
        next_pins.ack_error = nak_err;
    endfunction

    task report(input string what, input logic [7:0] got, input logic [7:0] exp_val);
        mismatches++;
        if (mismatches <= 40)
            $display("mismatch on %s at result %0d: got %0h, expected %0h",
                     what, results_seen, got, exp_val);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timing.setup_ticks      = SETUP_RESET;
            timing.half_bit_ticks   = HALF_RESET;
            timing.ack_settle_ticks = SETTLE_RESET;
            timing.ack_timeout      = TIMEOUT_RESET;
            ph            = PH_IDLE;
            hold_left     = 8'd0;
            bits_moved    = 0;
            shifter       = '0;
            last_read     = '0;
            polls         = 8'd0;
            scl_lvl       = 1'b1;
            sda_lvl       = 1'b1;
            nak_err       = 1'b0;
            mismatches    = 0;
            results_seen  = 0;
            dones_seen    = 0;
            timeouts_seen = 0;
            pins_q.delete();
            pending  <= 0;
            seq_busy <= 1'b0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    CFG_SETUP:   timing.setup_ticks      = cfg.data;
                    CFG_HALF:    timing.half_bit_ticks   = cfg.data;
                    CFG_SETTLE:  timing.ack_settle_ticks = cfg.data;
                    CFG_TIMEOUT: timing.ack_timeout      = cfg.data;
                    default:     ;
                endcase
            end
            // results leave before the item of this edge is predicted
            if (results.valid && results.ready)
            begin
                results_seen++;
                if (results.done_res === 1'b1)
                    dones_seen++;
                if (pins_q.size() == 0)
                    report("unexpected transfer", 8'd0, 8'd0);
                else
                begin
                    want = pins_q.pop_front();
                    if (results.scl_out !== want.scl_out)
                        report("scl_out", 8'(results.scl_out), 8'(want.scl_out));
                    if (results.sda_out !== want.sda_out)
                        report("sda_out", 8'(results.sda_out), 8'(want.sda_out));
                    if (results.busy_res !== want.busy_res)
                        report("busy_res", 8'(results.busy_res), 8'(want.busy_res));
                    if (results.done_res !== want.done_res)
                        report("done_res", 8'(results.done_res), 8'(want.done_res));
                    if (results.read_data !== want.read_data)
                        report("read_data", results.read_data, want.read_data);
                    if (results.ack_error !== want.ack_error)
                        report("ack_error", 8'(results.ack_error), 8'(want.ack_error));
                end
            end
            if (items.valid && items.ready)
                pins_q.push_back(next_pins(mode_t'(items.mode), items.write_data,
                                           items.sda_in));
            pending  <= pins_q.size();
            seq_busy <= (ph != PH_IDLE);
        end
    end

endmodule

@@ sim/tb_i2c_bit_level_master_core.sv @@
// i2c bit-level master: stimulus, channel pacing and verdict around the core
module tb_i2c_bit_level_master_core;
    import i2cbm_pkg::*;

    localparam logic [CFG_INDEX_W-1:0] CFG_NONE = CFG_INDEX_W'(4);

    logic clk = 1'b0;
    logic rst_n;
    logic quiet;
    logic hold_results;
    int   sda_high_pct;
    int   items_sent;
    int   settings_used;
    int   rnd_base;
    int   round_no;

    int   mismatches;
    int   pending;
    logic seq_busy;
    int   results_seen;
    int   dones_seen;
    int   timeouts_seen;

    i2cbm_item_if   items();
    i2cbm_result_if results();
    i2cbm_cfg_if    cfg();

    i2c_bit_level_master_core dut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .items   (items),
        .results (results),
        .cfg     (cfg)
    );

    i2cbm_sequence_check seq_check
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .items         (items),
        .results       (results),
        .cfg           (cfg),
        .mismatches    (mismatches),
        .pending       (pending),
        .seq_busy      (seq_busy),
        .results_seen  (results_seen),
        .dones_seen    (dones_seen),
        .timeouts_seen (timeouts_seen)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    initial
    begin
        #10_000_000;
        $display("i2c_bit_level_master_core test failed");
        $finish;
    end

    // receiver side: random stalls, a quiet stretch, and one long hold-off on request
    initial
    begin
        results.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_results)
            begin
                results.ready <= 1'b0;
                repeat (200) @(posedge clk);
                hold_results = 1'b0;
            end
            results.ready <= quiet || ($urandom_range(99) >= 13);
        end
    end

    function logic pick_sda();
        return ($urandom_range(99) < sda_high_pct);
    endfunction

    task automatic put_item(input mode_t m, input logic [7:0] d, input logic s);
        if (!quiet && $urandom_range(99) < 13)
        begin
            items.valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        items.valid      <= 1'b1;
        items.mode       <= m;
        items.write_data <= d;
        items.sda_in     <= s;
        @(posedge clk);
        while (!items.ready) @(posedge clk);
        items_sent++;
    endtask

    // ticks until the sequencer is idle again; seq_busy lags one item, so one extra tick
    task automatic finish_sequence();
        do
        begin
            if ($urandom_range(99) < 4)
                put_item(mode_t'($urandom_range(1, 7)), 8'($urandom), pick_sda());
            put_item(MODE_TICK, 8'($urandom), pick_sda());
        end
        while (seq_busy);
    endtask

    task automatic run_command(input mode_t m, input logic [7:0] d);
        put_item(m, d, pick_sda());
        finish_sequence();
    endtask

    task automatic wait_drained();
        items.valid <= 1'b0;
        do @(posedge clk); while (pending != 0 || seq_busy);
    endtask

    task automatic set_timing(input logic [7:0] setup_v, input logic [7:0] half_v,
                              input logic [7:0] settle_v, input logic [7:0] limit_v);
        logic [CFG_INDEX_W-1:0] idx [5];
        logic [CFG_DATA_W-1:0]  val [5];
        idx = '{CFG_SETUP, CFG_HALF, CFG_SETTLE, CFG_TIMEOUT,
                CFG_NONE + CFG_INDEX_W'($urandom_range(0, 251))};
        val = '{setup_v, half_v, settle_v, limit_v, CFG_DATA_W'($urandom)};
        foreach (idx[k])
        begin
            cfg.valid <= 1'b1;
            cfg.index <= idx[k];
            cfg.data  <= val[k];
            @(posedge clk);
            while (!cfg.ready) @(posedge clk);
        end
        cfg.valid <= 1'b0;
        settings_used++;
    endtask

    task automatic bus_transfer();
        run_command(MODE_START, 8'($urandom));
        run_command(MODE_WRITE, 8'($urandom));
        run_command(MODE_WAIT, 8'($urandom));
        repeat ($urandom_range(1, 3))
        begin
            if ($urandom_range(1) == 1)
            begin
                run_command(MODE_WRITE, 8'($urandom));
                run_command(MODE_WAIT, 8'($urandom));
            end
            else
            begin
                run_command(MODE_READ, 8'($urandom));
                run_command(($urandom_range(1) == 1) ? MODE_ACK : MODE_NACK, 8'($urandom));
            end
        end
        run_command(MODE_STOP, 8'($urandom));
    endtask

    task automatic noise_burst();
        repeat ($urandom_range(2, 5))
        begin
            if ($urandom_range(3) == 0)
                put_item(MODE_TICK, 8'($urandom), pick_sda());
            else
                run_command(mode_t'($urandom_range(1, 7)), 8'($urandom));
        end
    endtask

    initial
    begin
        rst_n            <= 1'b0;
        items.valid      <= 1'b0;
        items.mode       <= MODE_TICK;
        items.write_data <= 8'd0;
        items.sda_in     <= 1'b1;
        cfg.valid        <= 1'b0;
        cfg.index        <= CFG_SETUP;
        cfg.data         <= 8'd0;
        quiet            = 1'b0;
        hold_results     = 1'b0;
        sda_high_pct     = 50;
        items_sent       = 0;
        settings_used    = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset timing: idle tick, command while busy, byte extremes, ack and nack
        put_item(MODE_TICK, 8'h5A, 1'b1);
        put_item(MODE_START, 8'h00, 1'b0);
        put_item(MODE_WRITE, 8'hC3, 1'b0);
        finish_sequence();
        run_command(MODE_WRITE, 8'hFF);
        sda_high_pct = 0;
        run_command(MODE_WAIT, 8'h00);
        run_command(MODE_WRITE, 8'h00);
        sda_high_pct = 100;
        run_command(MODE_READ, 8'h00);
        run_command(MODE_ACK, 8'h00);
        sda_high_pct = 0;
        run_command(MODE_READ, 8'hFF);
        run_command(MODE_NACK, 8'h00);
        run_command(MODE_STOP, 8'h00);

        // zero holds and zero timeout: first high poll errors out into a stop
        wait_drained();
        set_timing(8'd0, 8'd0, 8'd0, 8'd0);
        sda_high_pct = 100;
        run_command(MODE_START, 8'h00);
        run_command(MODE_WAIT, 8'h00);
        sda_high_pct = 50;
        run_command(MODE_READ, 8'h00);
        run_command(MODE_STOP, 8'h00);

        wait_drained();
        set_timing(8'd1, 8'd1, 8'd1, 8'd1);

        rnd_base = items_sent;
        round_no = 0;
        while (items_sent - rnd_base < 250 || round_no < 4)
        begin
            if (round_no > 0 && round_no % 2 == 0)
            begin
                wait_drained();
                set_timing(8'($urandom_range(0, 3)), 8'($urandom_range(0, 2)),
                           8'($urandom_range(0, 3)), 8'($urandom_range(0, 8)));
            end
            quiet = (round_no >= 1 && round_no < 3);
            if (round_no == 3)
                hold_results = 1'b1;
            sda_high_pct = $urandom_range(10, 70);
            if ($urandom_range(99) < 80)
                bus_transfer();
            else
                noise_burst();
            round_no++;
        end
        quiet = 1'b0;

        wait_drained();
        repeat (4) @(posedge clk);
        $display("covered %0d items, %0d results, %0d completed commands, %0d ack timeouts",
                 items_sent, results_seen, dones_seen, timeouts_seen);
        $display("used %0d timing settings, zero holds included", settings_used);
        if (mismatches == 0 && pending == 0)
            $display("i2c_bit_level_master_core test passed");
        else
            $display("i2c_bit_level_master_core test failed");
        $finish;
    end

endmodule

@@ i2c_bit_level_master_core.f @@
rtl/i2cbm_pkg.sv
rtl/i2cbm_if.sv
rtl/i2cbm_seq.sv
rtl/i2c_bit_level_master_core.sv
sim/i2cbm_sequence_check.sv
sim/tb_i2c_bit_level_master_core.sv
